>>> rtl/obdpid_pkg.sv
// Shared types, constants and helper functions for the OBD PID reply decoder.
`default_nettype none

package obdpid_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    // Characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_ONE   = 8'h31;

    // Mode 01 PIDs with a formula
    localparam logic [7:0] PID_STATUS   = 8'h01;
    localparam logic [7:0] PID_LOAD     = 8'h04;
    localparam logic [7:0] PID_COOLANT  = 8'h05;
    localparam logic [7:0] PID_RPM      = 8'h0C;
    localparam logic [7:0] PID_SPEED    = 8'h0D;
    localparam logic [7:0] PID_INTAKE   = 8'h0F;
    localparam logic [7:0] PID_THROTTLE = 8'h11;
    localparam logic [7:0] PID_FUEL     = 8'h2F;

    localparam logic [7:0] TEMP_OFFSET  = 8'd40;
    localparam logic [7:0] PCT_SCALE    = 8'd100;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_GAIN = 1'b1;
    localparam logic [15:0] FULL_SCALE_RST   = 16'hFFFF;
    localparam logic [15:0] DEFAULT_GAIN_RST = 16'h0001;

    // Back-end datapath widths
    localparam int OP_A_W     = 14;            // (256*A+B)/4 fits in 14 bits
    localparam int OP_B_W     = 16;
    localparam int PROD_W     = OP_A_W + OP_B_W;

    // Constant divides by reciprocal multiply. Once the power-of-two part of the
    // divisor is shifted out every dividend is under 2^24, where ceil(2^s/d) is exact.
    localparam int DIV_IN_W     = 24;
    localparam int RECIP_W      = 25;
    localparam int RECIP_PROD_W = DIV_IN_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_255 = 25'd16843010;   // ceil(2^32/255)
    localparam logic [RECIP_W-1:0] RECIP_125 = 25'd17179870;   // ceil(2^31/125)
    localparam logic [RECIP_W-1:0] RECIP_25  = 25'd21474837;   // ceil(2^29/25)
    localparam int RECIP_SH_255 = 32;
    localparam int RECIP_SH_125 = 31;
    localparam int RECIP_SH_25  = 29;
    localparam int RPM_PRE_SH   = 6;           // 8000 = 64 * 125
    localparam int PCT_PRE_SH   = 2;           // 100 = 4 * 25

    typedef struct packed {
        logic [15:0] full_scale;
        logic [15:0] default_gain;
    } cfg_regs_t;

    typedef enum logic [2:0] {
        KIND_RPM,
        KIND_SPEED,
        KIND_PCT,
        KIND_TEMP,
        KIND_STATUS,
        KIND_OTHER
    } pid_kind_t;

    typedef enum logic [1:0] {
        DIV_NONE,
        DIV_BY_255,
        DIV_BY_100,
        DIV_BY_8000
    } div_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } back_state_t;

    // One finished line, handed from the parser to the arithmetic side
    typedef struct packed {
        logic      reply_ok;
        pid_kind_t kind;
        logic      data_ok;   // header found and enough digits for this PID
        logic [7:0] byte_a;
        logic [7:0] byte_b;
    } line_job_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h57;
        end
        return t[3:0];
    endfunction

    function automatic logic nibble_match(input logic [7:0] c, input logic [3:0] nib);
        return is_hex(c) && (hex_val(c) == nib);
    endfunction

    function automatic pid_kind_t classify(input logic [7:0] pid);
        pid_kind_t k;
        case (pid)
            PID_RPM:      k = KIND_RPM;
            PID_SPEED:    k = KIND_SPEED;
            PID_LOAD:     k = KIND_PCT;
            PID_THROTTLE: k = KIND_PCT;
            PID_FUEL:     k = KIND_PCT;
            PID_COOLANT:  k = KIND_TEMP;
            PID_INTAKE:   k = KIND_TEMP;
            PID_STATUS:   k = KIND_STATUS;
            default:      k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

>>> rtl/obdpid_front.sv
// Line parser: tracks the reply header and data digits, emits one job per ended non-empty line.
`default_nettype none

module obdpid_front
    import obdpid_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      char_valid,
    output logic           char_ready,
    input  wire logic [7:0] rx_char,
    input  wire logic [7:0] query_pid,
    input  wire logic      queue_full,
    output logic           push,
    output line_job_t      push_job
);

    logic [23:0] recent_reg, recent_next;
    logic        nonempty_reg, nonempty_next;
    logic        saw_reg, saw_next;
    logic        hm_reg, hm_next;
    logic [3:0]  dc_reg, dc_next;
    logic [15:0] ftb_reg, ftb_next;

    logic       accept;
    logic       is_eol;
    logic [3:0] hv;
    pid_kind_t  kind;
    logic       data_ok;

    assign char_ready = !queue_full;
    assign accept     = char_valid && char_ready;
    assign is_eol     = (rx_char == CH_CR) || (rx_char == CH_LF);
    assign hv         = hex_val(rx_char);
    assign kind       = classify(query_pid);

    always_comb begin
        case (kind)
            KIND_RPM:    data_ok = hm_reg && (dc_reg[3] || dc_reg[2]);
            KIND_STATUS: data_ok = hm_reg && dc_reg[3];
            default:     data_ok = hm_reg && (|dc_reg[3:1]);
        endcase
    end

    assign push = accept && is_eol && nonempty_reg;

    always_comb begin
        push_job.reply_ok = saw_reg;
        push_job.kind     = kind;
        push_job.data_ok  = data_ok;
        push_job.byte_a   = ftb_reg[15:8];
        push_job.byte_b   = ftb_reg[7:0];
    end

    always_comb begin
        recent_next   = recent_reg;
        nonempty_next = nonempty_reg;
        saw_next      = saw_reg;
        hm_next       = hm_reg;
        dc_next       = dc_reg;
        ftb_next      = ftb_reg;
        if (accept) begin
            if (is_eol) begin
                // an empty line changes nothing
                if (nonempty_reg) begin
                    recent_next   = '0;
                    nonempty_next = 1'b0;
                    saw_next      = 1'b0;
                    hm_next       = 1'b0;
                    dc_next       = '0;
                    ftb_next      = '0;
                end
            end else begin
                nonempty_next = 1'b1;
                if (recent_reg[7:0] == CH_FOUR && rx_char == CH_ONE) begin
                    saw_next = 1'b1;
                end
                if (hm_reg) begin
                    if (rx_char != CH_SPACE) begin
                        case (dc_reg)
                            4'd0:    ftb_next[15:12] = hv;
                            4'd1:    ftb_next[11:8]  = hv;
                            4'd2:    ftb_next[7:4]   = hv;
                            4'd3:    ftb_next[3:0]   = hv;
                            default: ftb_next        = ftb_reg;
                        endcase
                        if (dc_reg != 4'hF) begin
                            dc_next = dc_reg + 4'd1;
                        end
                    end
                end else if (recent_reg[23:16] == CH_FOUR && recent_reg[15:8] == CH_ONE &&
                             nibble_match(recent_reg[7:0], query_pid[7:4]) &&
                             nibble_match(rx_char, query_pid[3:0])) begin
                    hm_next = 1'b1;
                end
                recent_next = {recent_reg[15:0], rx_char};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg   <= '0;
            nonempty_reg <= 1'b0;
            saw_reg      <= 1'b0;
            hm_reg       <= 1'b0;
            dc_reg       <= '0;
            ftb_reg      <= '0;
        end else begin
            recent_reg   <= recent_next;
            nonempty_reg <= nonempty_next;
            saw_reg      <= saw_next;
            hm_reg       <= hm_next;
            dc_reg       <= dc_next;
            ftb_reg      <= ftb_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/obdpid_fifo.sv
// Small job queue between the line parser and the arithmetic back end.
`default_nettype none

module obdpid_fifo
    import obdpid_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire line_job_t push_job,
    output logic           full,
    input  wire logic      pop,
    output line_job_t      pop_job,
    output logic           empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    line_job_t           slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/obdpid_back.sv
// Arithmetic back end: formula select, multiply (twice for percent PIDs), reciprocal constant divide, saturate.
`default_nettype none

module obdpid_back
    import obdpid_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_regs_t  cfg,
    input  wire logic       job_valid,
    input  wire line_job_t  job,
    output logic            job_pop,
    output logic            res_valid,
    input  wire logic       res_ready,
    output logic            reply_ok,
    output logic [15:0]     scaled_value,
    output logic [6:0]      fault_code_count
);

    back_state_t state_reg, state_next;

    logic                  ok_reg, ok_next;
    logic [OP_A_W-1:0]     op_a_reg, op_a_next;
    logic [OP_B_W-1:0]     op_b_reg, op_b_next;
    div_sel_t              div_sel_reg, div_sel_next;
    logic                  pass2_reg, pass2_next;    // percent PIDs divide twice
    logic [PROD_W-1:0]     quo_reg, quo_next;
    logic [6:0]            fault_reg, fault_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_ok_reg, out_ok_next;
    logic [15:0]           out_val_reg, out_val_next;
    logic [6:0]            out_fault_reg, out_fault_next;

    logic [DIV_IN_W-1:0]     div_in;
    logic [RECIP_W-1:0]      recip;
    logic [RECIP_PROD_W-1:0] recip_prod;
    logic [PROD_W-1:0]       div_q;
    logic [15:0]             sat_val;
    logic [OP_A_W-1:0]       a_ext;
    logic                    slot_free;

    // power-of-two part of the divisor first, then the odd part by reciprocal
    always_comb begin
        case (div_sel_reg)
            DIV_BY_8000: begin
                div_in = quo_reg[RPM_PRE_SH+DIV_IN_W-1:RPM_PRE_SH];
                recip  = RECIP_125;
            end
            DIV_BY_100: begin
                div_in = quo_reg[PCT_PRE_SH+DIV_IN_W-1:PCT_PRE_SH];
                recip  = RECIP_25;
            end
            default: begin
                div_in = quo_reg[DIV_IN_W-1:0];
                recip  = RECIP_255;
            end
        endcase
    end

    assign recip_prod = RECIP_PROD_W'(div_in) * RECIP_PROD_W'(recip);

    always_comb begin
        case (div_sel_reg)
            DIV_BY_8000: div_q = PROD_W'(recip_prod[RECIP_PROD_W-1:RECIP_SH_125]);
            DIV_BY_100:  div_q = PROD_W'(recip_prod[RECIP_PROD_W-1:RECIP_SH_25]);
            default:     div_q = PROD_W'(recip_prod[RECIP_PROD_W-1:RECIP_SH_255]);
        endcase
    end

    assign sat_val   = (|quo_reg[PROD_W-1:16]) ? 16'hFFFF : quo_reg[15:0];
    assign a_ext     = OP_A_W'(job.byte_a);
    assign slot_free = !out_valid_reg || res_ready;

    assign res_valid        = out_valid_reg;
    assign reply_ok         = out_ok_reg;
    assign scaled_value     = out_val_reg;
    assign fault_code_count = out_fault_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = (div_sel_reg == DIV_NONE) ? ST_EMIT : ST_DIV;
            end
            ST_DIV: begin
                state_next = pass2_reg ? ST_MUL : ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        job_pop        = 1'b0;
        ok_next        = ok_reg;
        op_a_next      = op_a_reg;
        op_b_next      = op_b_reg;
        div_sel_next   = div_sel_reg;
        pass2_next     = pass2_reg;
        quo_next       = quo_reg;
        fault_next     = fault_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_ok_next    = out_ok_reg;
        out_val_next   = out_val_reg;
        out_fault_next = out_fault_reg;
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    job_pop      = 1'b1;
                    ok_next      = job.reply_ok;
                    pass2_next   = 1'b0;
                    op_a_next    = '0;
                    op_b_next    = cfg.full_scale;
                    div_sel_next = DIV_NONE;
                    if (job.reply_ok) begin
                        case (job.kind)
                            KIND_RPM: begin
                                if (job.data_ok) begin
                                    op_a_next = {job.byte_a, job.byte_b[7:2]};
                                end
                                div_sel_next = DIV_BY_8000;
                            end
                            KIND_SPEED: begin
                                if (job.data_ok) begin
                                    op_a_next = a_ext;
                                end
                                div_sel_next = DIV_BY_255;
                            end
                            KIND_PCT: begin
                                // A*100/255 first, then *full_scale/100
                                if (job.data_ok) begin
                                    op_a_next = a_ext;
                                end
                                op_b_next    = OP_B_W'(PCT_SCALE);
                                div_sel_next = DIV_BY_255;
                                pass2_next   = 1'b1;
                            end
                            KIND_TEMP: begin
                                // raw + 40 is just A, or 40 with no data
                                op_a_next    = job.data_ok ? a_ext : OP_A_W'(TEMP_OFFSET);
                                div_sel_next = DIV_BY_255;
                            end
                            KIND_STATUS: begin
                                if (job.data_ok) begin
                                    fault_next = job.byte_a[6:0];
                                    op_a_next  = OP_A_W'(job.byte_a[6:0]);
                                end
                                op_b_next = OP_B_W'(1);
                            end
                            default: begin
                                if (job.data_ok) begin
                                    op_a_next = a_ext;
                                end
                                op_b_next = cfg.default_gain;
                            end
                        endcase
                    end
                end
            end
            ST_MUL: begin
                quo_next = PROD_W'(op_a_reg) * PROD_W'(op_b_reg);
            end
            ST_DIV: begin
                quo_next = div_q;
                if (pass2_reg) begin
                    op_a_next    = div_q[OP_A_W-1:0];
                    op_b_next    = cfg.full_scale;
                    div_sel_next = DIV_BY_100;
                    pass2_next   = 1'b0;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_ok_next    = ok_reg;
                    out_val_next   = sat_val;
                    out_fault_next = fault_reg;
                end
            end
            default: begin
                job_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
            pass2_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
            pass2_reg     <= pass2_next;
        end
    end

    always_ff @(posedge aclk) begin
        ok_reg        <= ok_next;
        op_a_reg      <= op_a_next;
        op_b_reg      <= op_b_next;
        div_sel_reg   <= div_sel_next;
        quo_reg       <= quo_next;
        out_ok_reg    <= out_ok_next;
        out_val_reg   <= out_val_next;
        out_fault_reg <= out_fault_next;
    end

endmodule

`default_nettype wire

>>> rtl/obd_pid_response_decoder_unit.sv
// Top level of the OBD mode 01 PID reply decoder: config registers and block wiring.
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+-----------------------------------------------
//  s_      | in  | s_valid / s_ready  | s_rx_char[7:0], s_query_pid[7:0]
//  m_      | out | m_valid / m_ready  | m_reply_ok, m_scaled_value[15:0],
//          |     |                    |   m_fault_code_count[6:0]
//  cfg_    | in  | cfg_wr_en          | cfg_index[0], cfg_wr_data[15:0]
//
// Flow: one character word per cycle while s_ready is high. A line end queues a job;
//   the back end takes one job at a time: multiply then emit for PIDs without a divide,
//   multiply, reciprocal divide, emit for one divide, and two such passes for percent PIDs.
// Reset: aresetn synchronous, active low; config returns to full_scale 65535,
//   default_gain 1; line state, queue and fault count clear.
// Stalls: s_ready drops only while the line-job queue is full; m_ready low holds
//   the output register and, once the queue fills, the input side.
`default_nettype none

module obd_pid_response_decoder_unit
    import obdpid_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF   // line jobs in flight, 2 or more
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // character input
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_rx_char,
    input  wire logic [7:0]           s_query_pid,
    // decoded result
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_reply_ok,
    output logic [15:0]               m_scaled_value,
    output logic [6:0]                m_fault_code_count,
    // register writes
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_wr_data
);

    cfg_regs_t cfg_reg, cfg_next;

    logic      q_push, q_full, q_pop, q_empty;
    line_job_t q_in_job, q_out_job;

    // config register file, write only
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FULL_SCALE:   cfg_next.full_scale   = cfg_wr_data;
                CFG_DEFAULT_GAIN: cfg_next.default_gain = cfg_wr_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.full_scale   <= FULL_SCALE_RST;
            cfg_reg.default_gain <= DEFAULT_GAIN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: per-character parse, one job per ended non-empty line
    obdpid_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .char_valid (s_valid),
        .char_ready (s_ready),
        .rx_char    (s_rx_char),
        .query_pid  (s_query_pid),
        .queue_full (q_full),
        .push       (q_push),
        .push_job   (q_in_job)
    );

    obdpid_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_in_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_out_job),
        .empty    (q_empty)
    );

    // back: formula, multiply, divide, saturate, output register
    obdpid_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .job_valid        (!q_empty),
        .job              (q_out_job),
        .job_pop          (q_pop),
        .res_valid        (m_valid),
        .res_ready        (m_ready),
        .reply_ok         (m_reply_ok),
        .scaled_value     (m_scaled_value),
        .fault_code_count (m_fault_code_count)
    );

endmodule

`default_nettype wire

>>> rtl/obdpid_checker.sv
// Port-level checks for the PID reply decoder, bound to the top level.
`default_nettype none

module obdpid_checker
    import obdpid_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic [7:0]           s_rx_char,
    input wire logic [7:0]           s_query_pid,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic                 m_reply_ok,
    input wire logic [15:0]          m_scaled_value,
    input wire logic [6:0]           m_fault_code_count,
    input wire logic                 cfg_wr_en,
    input wire logic [CFG_IDX_W-1:0] cfg_index,
    input wire logic [15:0]          cfg_wr_data
);

    // no result word right after reset
    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // queue is empty after reset, so input is ready
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // a line without the reply marker never carries a value
    a_no_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_reply_ok) |-> (m_scaled_value == 16'h0000))
        else $error("value present without reply marker");

    // stalled result word holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_reply_ok) &&
                                  $stable(m_scaled_value) && $stable(m_fault_code_count)))
        else $error("stalled result word changed");

endmodule

bind obd_pid_response_decoder_unit obdpid_checker u_checker (.*);

`default_nettype wire
